// ===== rtl/stepped_brightness_duty_controller_defines.svh =====
// assertion macros for the stepped brightness duty controller
// no dependencies; included by the top level only
`ifndef STEPPED_BRIGHTNESS_DUTY_CONTROLLER_DEFINES_SVH
`define STEPPED_BRIGHTNESS_DUTY_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// plain clocked property, off while reset is low
`define SBDC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sbdc assertion failed");
// property checked only while a qualifying valid is high
`define SBDC_ASSERT_VLD(lbl, clk, rstn, vld, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (vld) |-> (prop)) \
    else $error("sbdc assertion failed");
`else
`define SBDC_ASSERT(lbl, clk, rstn, prop)
`define SBDC_ASSERT_VLD(lbl, clk, rstn, vld, prop)
`endif

`endif

// ===== rtl/sbdc_pkg.sv =====
// types, constants and the level lookup of the stepped brightness duty controller
// no dependencies
package sbdc_pkg;

  localparam int unsigned DutyBitsDefault = 10;
  localparam int unsigned PctBits         = 7;

  localparam logic [PctBits-1:0] PctMax = 7'd100;

  localparam logic [PctBits-1:0] Level0Reset = 7'd20;
  localparam logic [PctBits-1:0] Level1Reset = 7'd40;
  localparam logic [PctBits-1:0] Level2Reset = 7'd60;
  localparam logic [PctBits-1:0] Level3Reset = 7'd100;

  localparam logic [PctBits-1:0] BaseReset  = 7'd100;
  localparam logic [1:0]         LevelReset = 2'd3;
  localparam logic [1:0]         LevelTop   = 2'd3;
  localparam logic [1:0]         LevelBot   = 2'd0;

  typedef enum logic [1:0] {
    REQ_SWITCH = 2'd0,
    REQ_SET    = 2'd1,
    REQ_GATE   = 2'd2
  } req_e;

  typedef logic [3:0][PctBits-1:0] levels_t;

  // one processed item between the state stage and the duty stage
  typedef struct packed {
    logic [PctBits-1:0] eff;
    logic [PctBits-1:0] brightness;
    logic [1:0]         level;
    logic               gate;
    logic               status;
  } mid_t;

  // exact match first, else nearest table entry, ties to the lower one
  function automatic logic [1:0] lookup_level(input logic [PctBits-1:0] b,
                                              input levels_t lv);
    logic [1:0] idx;
    logic       done;
    idx  = LevelTop;
    done = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!done && lv[i] == b) begin
        idx  = 2'(i);
        done = 1'b1;
      end
    end
    if (!done) begin
      if (b <= lv[0]) begin
        idx  = LevelBot;
        done = 1'b1;
      end else if (b >= lv[3]) begin
        idx  = LevelTop;
        done = 1'b1;
      end
      for (int k = 1; k < 4; k++) begin
        if (!done && b < lv[k]) begin
          if (lv[k-1] <= b && (b - lv[k-1]) <= (lv[k] - b)) begin
            idx = 2'(k - 1);
          end else begin
            idx = 2'(k);
          end
          done = 1'b1;
        end
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/stepped_brightness_duty_controller.sv =====
// top level of the stepped brightness duty controller
// depends on sbdc_pkg and stepped_brightness_duty_controller_defines.svh
`include "stepped_brightness_duty_controller_defines.svh"
// Usage
//   input channel: one beat per request (switch sample, set brightness, set
//   gate), valid/ready handshake; every beat yields exactly one result beat
//   on the output channel, in order
//   config port: cfg_we_i writes cfg_data_i into level register cfg_idx_i in
//   the same edge; write only while no beat is in flight
//   pipeline: input register, state stage, duty stage; a result is valid
//   once its beat has passed through all three registers
//   throughput: one beat per cycle while no result is held; the state
//   stage updates brightness, level and gate as a beat leaves the input
//   register, so the next beat sees the new state right away
//   duty comes from a constant table indexed by effective brightness
//   reset: base brightness 100, level 3, gate open, switch history clear,
//   level table 20/40/60/100, pipeline empty
//   stall: a held result back-pressures stage by stage; ready drops only
//   once all three registers hold beats
module stepped_brightness_duty_controller
  import sbdc_pkg::*;
#(
  parameter int unsigned DUTY_BITS = DutyBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [PctBits-1:0]   cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic                 brighter_pressed_i,
  input  logic                 dimmer_pressed_i,
  input  logic [PctBits-1:0]   new_brightness_i,
  input  logic                 gate_open_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DUTY_BITS-1:0] duty_o,
  output logic [PctBits-1:0]   brightness_now_o,
  output logic [1:0]           level_now_o,
  output logic                 gate_now_o,
  output logic                 led_red_o,
  output logic                 led_yellow_o,
  output logic                 led_blue_o,
  output logic                 status_o
);

  localparam int          FullScale = (1 << DUTY_BITS) - 1;
  localparam int unsigned LutDepth  = 1 << PctBits;

  // duty per effective brightness, zero at or above full brightness
  logic [DUTY_BITS-1:0] duty_lut [LutDepth];
  for (genvar g = 0; g < LutDepth; g++) begin : g_lut
    localparam int Val = (g >= 100) ? 0 : (((100 - g) * FullScale + 50) / 100);
    assign duty_lut[g] = DUTY_BITS'(Val);
  end

  // level table
  levels_t levels_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= {Level3Reset, Level2Reset, Level1Reset, Level0Reset};
    end else if (cfg_we_i) begin
      levels_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // pipeline handshake
  logic v0_q, v1_q, v2_q;
  logic rdy0, rdy1, rdy2;
  logic mv01, mv12;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign mv01 = v0_q && rdy1;
  assign mv12 = v1_q && rdy2;
  assign in_ready_o = rdy0;

  // input register
  logic [1:0]         req_q;
  logic               up_q, down_q, gate_req_q;
  logic [PctBits-1:0] nb_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy0) begin
      req_q      <= req_type_i;
      up_q       <= brighter_pressed_i;
      down_q     <= dimmer_pressed_i;
      nb_q       <= new_brightness_i;
      gate_req_q <= gate_open_i;
    end
  end

  // block state
  logic [PctBits-1:0] base_q, base_d;
  logic [1:0]         level_q, level_d;
  logic               gate_q, gate_d;
  logic               blast_q, blast_d;
  logic               dlast_q, dlast_d;
  logic               status_d;

  always_comb begin
    logic [PctBits-1:0] base_up;
    logic [1:0]         level_up;
    base_d   = base_q;
    level_d  = level_q;
    gate_d   = gate_q;
    blast_d  = blast_q;
    dlast_d  = dlast_q;
    status_d = 1'b0;
    base_up  = base_q;
    level_up = level_q;
    case (req_e'(req_q))
      REQ_SWITCH: begin
        // brighter step first, dimmer step sees its index
        if (up_q && !blast_q && level_q != LevelTop) begin
          base_up  = levels_q[2'(level_q + 2'd1)];
          level_up = lookup_level(base_up, levels_q);
        end
        base_d  = base_up;
        level_d = level_up;
        if (down_q && !dlast_q && level_up != LevelBot) begin
          base_d  = levels_q[2'(level_up - 2'd1)];
          level_d = lookup_level(base_d, levels_q);
        end
        blast_d = up_q;
        dlast_d = down_q;
      end
      REQ_SET: begin
        if (nb_q > PctMax) begin
          status_d = 1'b1;
        end else begin
          base_d  = nb_q;
          level_d = lookup_level(nb_q, levels_q);
        end
      end
      REQ_GATE: begin
        gate_d = gate_req_q;
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseReset;
      level_q <= LevelReset;
      gate_q  <= 1'b1;
      blast_q <= 1'b0;
      dlast_q <= 1'b0;
    end else if (mv01) begin
      base_q  <= base_d;
      level_q <= level_d;
      gate_q  <= gate_d;
      blast_q <= blast_d;
      dlast_q <= dlast_d;
    end
  end

  // state stage result
  mid_t mid_q;
  always_ff @(posedge clk_i) begin
    if (mv01) begin
      mid_q.eff        <= gate_d ? base_d : '0;
      mid_q.brightness <= base_d;
      mid_q.level      <= level_d;
      mid_q.gate       <= gate_d;
      mid_q.status     <= status_d;
    end
  end

  // duty stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_o           <= '0;
      brightness_now_o <= BaseReset;
      level_now_o      <= LevelReset;
      gate_now_o       <= 1'b1;
      led_red_o        <= 1'b0;
      led_yellow_o     <= 1'b0;
      led_blue_o       <= 1'b0;
      status_o         <= 1'b0;
    end else if (mv12) begin
      duty_o           <= duty_lut[mid_q.eff];
      brightness_now_o <= mid_q.brightness;
      level_now_o      <= mid_q.level;
      gate_now_o       <= mid_q.gate;
      led_red_o        <= (mid_q.level == 2'd3);
      led_yellow_o     <= (mid_q.level == 2'd2);
      led_blue_o       <= (mid_q.level == 2'd1);
      status_o         <= mid_q.status;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_q <= in_valid_i;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  assign out_valid_o = v2_q;

  // state moves only when a beat leaves the input register
  `SBDC_ASSERT(a_state_hold, clk_i, rst_ni, !mv01 |=> $stable(base_q) && $stable(level_q))
  // a blanked gate always gives full-scale off time
  `SBDC_ASSERT_VLD(a_blank_duty, clk_i, rst_ni, out_valid_o && !gate_now_o,
    duty_o == DUTY_BITS'(FullScale))
  // at most one indicator lit
  `SBDC_ASSERT(a_led_onehot, clk_i, rst_ni, $onehot0({led_red_o, led_yellow_o, led_blue_o}))

endmodule

// ===== tb/stepped_brightness_duty_controller_tb.sv =====
// testbench of the stepped brightness duty controller: directed and random request beats,
// a scoreboard class that predicts every result beat and checks them in order
// depends on sbdc_pkg and the rtl top level stepped_brightness_duty_controller
module stepped_brightness_duty_controller_tb;
  import sbdc_pkg::*;

  localparam int unsigned DutyFull     = (1 << DutyBitsDefault) - 1;
  localparam logic [1:0]  REQ_UNKNOWN  = 2'd3;   // no such request, answered with status 1
  localparam int unsigned NumLevels    = 4;
  localparam int unsigned MaxGap       = 9;
  localparam int unsigned LongHold     = 150;    // receiver back-pressure stretch in cycles
  localparam int unsigned DrainCycles  = 8;      // pipeline is three deep, leave some margin
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned PhaseItems   = 280;
  localparam int unsigned MaxPrints    = 100;
  localparam int unsigned TimeoutLimit = 3000000;

  // one result beat, field order matches the packing of seen_beat below
  typedef struct packed {
    logic [DutyBitsDefault-1:0] duty;
    logic [PctBits-1:0]         brightness;
    logic [1:0]                 level;
    logic                       gate;
    logic                       red;
    logic                       yellow;
    logic                       blue;
    logic                       status;
  } duty_beat_t;

  // predicts the controller state and holds the result beats still to come
  class duty_scoreboard;
    levels_t            levels;
    logic [PctBits-1:0] base;
    logic [1:0]         level;
    logic               gate;
    logic               up_last;
    logic               dn_last;
    duty_beat_t         want_q[$];
    int                 errors;

    function new();
      levels  = {Level3Reset, Level2Reset, Level1Reset, Level0Reset};
      base    = BaseReset;
      level   = LevelReset;
      gate    = 1'b1;
      up_last = 1'b0;
      dn_last = 1'b0;
      errors  = 0;
    endfunction

    // exact entry first, else nearest entry with ties to the lower one
    function logic [1:0] nearest_level(int b);
      int t[NumLevels];
      for (int i = 0; i < NumLevels; i++) t[i] = int'(levels[i]);
      for (int i = 0; i < NumLevels; i++) begin
        if (t[i] == b) return 2'(i);
      end
      if (b <= t[0]) return LevelBot;
      if (b >= t[3]) return LevelTop;
      for (int k = 1; k < NumLevels; k++) begin
        if (b < t[k]) begin
          if (t[k-1] <= b && (b - t[k-1]) <= (t[k] - b)) return 2'(k - 1);
          return 2'(k);
        end
      end
      return LevelTop;
    endfunction

    function int unsigned duty_for(int e);
      if (e >= 100) return 0;
      if (e == 0) return DutyFull;
      return ((100 - e) * DutyFull + 50) / 100;
    endfunction

    function void set_base(logic [PctBits-1:0] b);
      base  = b;
      level = nearest_level(int'(b));
    endfunction

    function void note_input(logic [1:0] kind, logic up, logic dn,
                             logic [PctBits-1:0] pct, logic go);
      duty_beat_t w;
      w.status = 1'b0;
      case (kind)
        REQ_SWITCH: begin
          // brighter edge first, the dimmer edge sees the index it leaves
          if (up && !up_last && level != LevelTop) set_base(levels[level + 2'd1]);
          if (dn && !dn_last && level != LevelBot) set_base(levels[level - 2'd1]);
          up_last = up;
          dn_last = dn;
        end
        REQ_SET: begin
          if (pct > PctMax) w.status = 1'b1;
          else set_base(pct);
        end
        REQ_GATE: gate = go;
        default: w.status = 1'b1;
      endcase
      w.duty       = DutyBitsDefault'(duty_for(gate ? int'(base) : 0));
      w.brightness = base;
      w.level      = level;
      w.gate       = gate;
      w.red        = (level == 2'd3);
      w.yellow     = (level == 2'd2);
      w.blue       = (level == 2'd1);
      want_q.push_back(w);
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrints) $display("mismatch: %s", msg);
    endtask

    task check_result(duty_beat_t got);
      duty_beat_t w;
      if (want_q.size() == 0) begin
        report("result beat with no prediction waiting");
      end else begin
        w = want_q.pop_front();
        if (got.duty != w.duty)
          report($sformatf("duty got %0d want %0d", got.duty, w.duty));
        if (got.brightness != w.brightness)
          report($sformatf("brightness got %0d want %0d", got.brightness, w.brightness));
        if (got.level != w.level)
          report($sformatf("level got %0d want %0d", got.level, w.level));
        if (got.gate != w.gate)
          report($sformatf("gate got %0d want %0d", got.gate, w.gate));
        if (got.red != w.red)
          report($sformatf("led red got %0d want %0d", got.red, w.red));
        if (got.yellow != w.yellow)
          report($sformatf("led yellow got %0d want %0d", got.yellow, w.yellow));
        if (got.blue != w.blue)
          report($sformatf("led blue got %0d want %0d", got.blue, w.blue));
        if (got.status != w.status)
          report($sformatf("status got %0d want %0d", got.status, w.status));
      end
    endtask
  endclass

  // clock, reset and every block input start at known values
  logic                       clk_i              = 1'b0;
  logic                       rst_ni             = 1'b0;
  logic                       cfg_we_i           = 1'b0;
  logic [1:0]                 cfg_idx_i          = '0;
  logic [PctBits-1:0]         cfg_data_i         = '0;
  logic                       in_valid_i         = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 req_type_i         = REQ_SWITCH;
  logic                       brighter_pressed_i = 1'b0;
  logic                       dimmer_pressed_i   = 1'b0;
  logic [PctBits-1:0]         new_brightness_i   = '0;
  logic                       gate_open_i        = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i        = 1'b0;
  logic [DutyBitsDefault-1:0] duty_o;
  logic [PctBits-1:0]         brightness_now_o;
  logic [1:0]                 level_now_o;
  logic                       gate_now_o;
  logic                       led_red_o;
  logic                       led_yellow_o;
  logic                       led_blue_o;
  logic                       status_o;

  duty_scoreboard sb;
  duty_beat_t     seen_beat;

  // shared between the sender and the receiver
  bit no_idle      = 1'b0;   // a stretch where neither side idles
  bit hold_pending = 1'b0;   // asks the receiver for one long hold-off

  always #4 clk_i = ~clk_i;

  stepped_brightness_duty_controller u_top (.*);

  assign seen_beat = {duty_o, brightness_now_o, level_now_o, gate_now_o,
                      led_red_o, led_yellow_o, led_blue_o, status_o};

  // one process samples both channels, so a result is always checked against
  // predictions of beats taken at earlier edges
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(seen_beat);
      if (in_valid_i && in_ready_o)
        sb.note_input(req_type_i, brighter_pressed_i, dimmer_pressed_i,
                      new_brightness_i, gate_open_i);
    end
  end

  // offer one request beat after a random gap and hold it until taken
  task automatic drive_req(input logic [1:0] kind, input logic up, input logic dn,
                           input logic [PctBits-1:0] pct, input logic go);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    req_type_i         <= kind;
    brighter_pressed_i <= up;
    dimmer_pressed_i   <= dn;
    new_brightness_i   <= pct;
    gate_open_i        <= go;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // unused fields carry random junk, the block must ignore them
  task automatic send_switch(input logic up, input logic dn);
    drive_req(REQ_SWITCH, up, dn, PctBits'($urandom), 1'($urandom));
  endtask

  task automatic send_pct(input logic [PctBits-1:0] pct);
    drive_req(REQ_SET, 1'($urandom), 1'($urandom), pct, 1'($urandom));
  endtask

  task automatic send_gate(input logic go);
    drive_req(REQ_GATE, 1'($urandom), 1'($urandom), PctBits'($urandom), go);
  endtask

  // stop offering and wait until every predicted beat has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // back-to-back register writes, only while the pipeline is empty
  task automatic load_table(input levels_t tbl);
    for (int i = 0; i < NumLevels; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= tbl[i];
      @(posedge clk_i);
      sb.levels[i] = tbl[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int n, input bit hold);
    int unsigned        pick;
    logic [PctBits-1:0] pct;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // long receiver stall while the sender keeps going fills the pipeline
      if (hold && i == 40) hold_pending = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // press and release patterns, both switches random
        drive_req(REQ_SWITCH, 1'($urandom), 1'($urandom), PctBits'($urandom),
                  1'($urandom));
      end else if (pick < 80) begin
        case ($urandom_range(0, 3))
          0: pct = sb.levels[$urandom_range(0, NumLevels - 1)];
          // one off a table entry hits the nearest and tie rules
          1: pct = sb.levels[$urandom_range(0, NumLevels - 1)]
                   + PctBits'($urandom_range(0, 2)) - 7'd1;
          2: pct = PctBits'($urandom_range(0, 100));
          default: pct = PctBits'($urandom);
        endcase
        drive_req(REQ_SET, 1'($urandom), 1'($urandom), pct, 1'($urandom));
      end else if (pick < 95) begin
        drive_req(REQ_GATE, 1'($urandom), 1'($urandom), PctBits'($urandom),
                  1'($urandom));
      end else begin
        drive_req(REQ_UNKNOWN, 1'($urandom), 1'($urandom), PctBits'($urandom),
                  1'($urandom));
      end
    end
  endtask

  // result side: random stall per beat, or one long hold-off on request
  initial begin : result_sink
    int unsigned wait_cycles;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        wait_cycles  = LongHold;
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, MaxGap);
      end
      if (wait_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    levels_t tbl;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset table 20/40/60/100
    send_switch(1'b1, 1'b0);   // brighter at the top entry, no change
    send_switch(1'b0, 1'b0);
    send_switch(1'b0, 1'b1);   // dimmer edge, down to 60
    send_switch(1'b0, 1'b1);   // held, no edge
    send_switch(1'b1, 1'b1);   // brighter edge only, back to 100
    send_switch(1'b0, 1'b0);
    send_switch(1'b1, 1'b1);   // both edges: brighter stuck at top, then dimmer
    send_switch(1'b0, 1'b0);
    send_pct(7'd0);            // full-scale duty
    send_switch(1'b0, 1'b1);   // dimmer at the bottom entry, no change
    send_switch(1'b0, 1'b0);
    send_pct(7'd100);          // zero duty
    send_pct(7'd101);          // refused
    send_pct(7'd127);          // refused
    send_pct(7'd50);           // tie between 40 and 60 goes low
    send_pct(7'd51);
    send_pct(7'd30);           // tie between 20 and 40 goes low
    send_pct(7'd10);           // below the table
    send_gate(1'b0);           // blanked
    send_pct(7'd80);           // stored while blanked
    send_gate(1'b1);
    drive_req(REQ_UNKNOWN, 1'b1, 1'b1, 7'd127, 1'b0);
    send_pct(7'd1);
    send_pct(7'd99);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: tbl = {Level3Reset, Level2Reset, Level1Reset, Level0Reset};
        1: tbl = {7'd100, 7'd100, 7'd0, 7'd0};
        2: begin
          tbl[0] = PctBits'($urandom_range(0, 40));
          tbl[1] = tbl[0] + PctBits'($urandom_range(0, 20));
          tbl[2] = tbl[1] + PctBits'($urandom_range(0, 20));
          tbl[3] = tbl[2] + PctBits'($urandom_range(0, 20));
        end
        3: begin
          // unordered table
          for (int i = 0; i < NumLevels; i++) tbl[i] = PctBits'($urandom_range(0, 100));
        end
        4: tbl = {7'd0, 7'd25, 7'd75, 7'd100};
        default: tbl = {7'd127, 7'd90, 7'd50, 7'd0};   // top entry past 100
      endcase
      load_table(tbl);
      run_phase(PhaseItems, (p == 1 || p == 4));
      drain();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutLimit);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== stepped_brightness_duty_controller.f =====
+incdir+rtl
rtl/sbdc_pkg.sv
rtl/stepped_brightness_duty_controller.sv
tb/stepped_brightness_duty_controller_tb.sv
